[hdl/rdg_pkg.sv]
// ---------------------------------------------------------------------------
// rdg_pkg: shared types and constants of the reaction-diffusion grid
// op codes, register indexes, field widths and the 32-bit saturation helper
// ---------------------------------------------------------------------------
package rdg_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned CFG_W     = 17;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned SIDE_W    = 5;
  localparam int unsigned CNT_W     = 16;
  localparam int unsigned SPOT_W    = 16;
  localparam int unsigned DIFF_W    = 17;
  localparam int unsigned OP_W      = 2;
  localparam int unsigned REG_FRAC  = 16;
  localparam int unsigned SUM_W     = 35;  // six neighbours of 32 bits
  localparam int unsigned WIDE_W    = 66;

  localparam logic [OP_W-1:0] OP_WRITE  = 2'd0;
  localparam logic [OP_W-1:0] OP_RUN    = 2'd1;
  localparam logic [OP_W-1:0] OP_READ   = 2'd2;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_SIDE_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIDE_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIDE_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ITER   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPOT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DIFF_A = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_DIFF_B = 3'd6;

  localparam logic [DIFF_W-1:0] DIFF_ONE = 17'd65536;

  typedef struct packed {
    logic [SPOT_W-1:0] spot;
    logic [DIFF_W-1:0] diff_a;
    logic [DIFF_W-1:0] diff_b;
  } coeff_t;

  typedef struct packed {
    logic                     done;
    logic signed [DATA_W-1:0] delta_a;
    logic signed [DATA_W-1:0] delta_b;
  } calc_res_t;

  localparam logic signed [WIDE_W-1:0] SAT_MAX = 66'sd2147483647;
  localparam logic signed [WIDE_W-1:0] SAT_MIN = -66'sd2147483648;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
    if (v > SAT_MAX) return SAT_MAX[DATA_W-1:0];
    if (v < SAT_MIN) return SAT_MIN[DATA_W-1:0];
    return v[DATA_W-1:0];
  endfunction

endpackage

[hdl/rdg_delta_calc.sv]
// ---------------------------------------------------------------------------
// rdg_delta_calc: per-voxel delta pipeline
// four stages: a*b and laplacians, reaction terms, coefficient products,
// final sum with saturation
// ---------------------------------------------------------------------------
module rdg_delta_calc
  import rdg_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  coeff_t                   coeff_i,
  input  logic signed [DATA_W-1:0] a_i,
  input  logic signed [DATA_W-1:0] b_i,
  input  logic signed [DATA_W-1:0] noise_i,
  input  logic signed [SUM_W-1:0]  sum_a_i,
  input  logic signed [SUM_W-1:0]  sum_b_i,
  output calc_res_t                res_o
);

  localparam int unsigned LAP_W = SUM_W + 1;
  localparam int unsigned PR_W  = SPOT_W + 1 + DATA_W;
  localparam int unsigned PD_W  = DIFF_W + 1 + LAP_W;
  localparam logic signed [WIDE_W-1:0] SIXTEEN = 66'sd16 <<< FRAC_BITS;

  logic v1_q, v2_q, v3_q, v4_q;

  logic signed [2*DATA_W-1:0] ab_q;
  logic signed [LAP_W-1:0]    la1_q, lb1_q, la2_q, lb2_q;
  logic signed [DATA_W-1:0]   b1_q, n1_q, ra_q, rb_q;
  logic signed [PR_W-1:0]     pa_q, pb_q;
  logic signed [PD_W-1:0]     qa_q, qb_q;
  logic signed [DATA_W-1:0]   da_q, db_q;

  logic signed [DATA_W-1:0] ab_sat;
  logic [DIFF_W-1:0]        dfa, dfb;

  always_comb begin
    ab_sat = sat32(WIDE_W'(ab_q >>> FRAC_BITS));
    dfa    = (coeff_i.diff_a > DIFF_ONE) ? DIFF_ONE : coeff_i.diff_a;
    dfb    = (coeff_i.diff_b > DIFF_ONE) ? DIFF_ONE : coeff_i.diff_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= start_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    // stage 1: product and laplacians (sum - 6*center)
    ab_q  <= a_i * b_i;
    la1_q <= LAP_W'(sum_a_i) - (LAP_W'(a_i) <<< 2) - (LAP_W'(a_i) <<< 1);
    lb1_q <= LAP_W'(sum_b_i) - (LAP_W'(b_i) <<< 2) - (LAP_W'(b_i) <<< 1);
    b1_q  <= b_i;
    n1_q  <= noise_i;
    // stage 2: reaction terms
    ra_q  <= sat32(SIXTEEN - WIDE_W'(ab_sat));
    rb_q  <= sat32(WIDE_W'(ab_sat) - WIDE_W'(b1_q) - WIDE_W'(n1_q));
    la2_q <= la1_q;
    lb2_q <= lb1_q;
    // stage 3: coefficient products
    pa_q  <= $signed({1'b0, coeff_i.spot}) * ra_q;
    pb_q  <= $signed({1'b0, coeff_i.spot}) * rb_q;
    qa_q  <= $signed({1'b0, dfa}) * la2_q;
    qb_q  <= $signed({1'b0, dfb}) * lb2_q;
    // stage 4: floor, add, clamp
    da_q  <= sat32(WIDE_W'(pa_q >>> REG_FRAC) + WIDE_W'(qa_q >>> REG_FRAC));
    db_q  <= sat32(WIDE_W'(pb_q >>> REG_FRAC) + WIDE_W'(qb_q >>> REG_FRAC));
  end

  assign res_o.done    = v4_q;
  assign res_o.delta_a = da_q;
  assign res_o.delta_b = db_q;

endmodule

[hdl/reaction_diffusion_grid_3d.sv]
// ---------------------------------------------------------------------------
// reaction_diffusion_grid_3d: turing reaction-diffusion on a periodic 3d grid
// concentrations and noise/delta words live in two single-port-read memories
// ---------------------------------------------------------------------------
// A noise write goes into the aux memory as its beat is taken. A voxel read
// passes through ST_RDW and its result beat is registered; no new command is
// taken while that beat waits. A run first sets both fields to 4.0 over the n
// active voxels, then per sweep makes a delta pass over every voxel
// (seven reads of the concentration memory, one per cycle, for the center and
// its six wrapped neighbours, then the four-stage delta pipeline) and an update
// pass over every voxel (read, then write back). The single read port of the
// concentration memory and the delta pipeline shape this schedule. There is
// no clearing pass; concentrations are defined only after the first run.
// ---------------------------------------------------------------------------
module reaction_diffusion_grid_3d
  import rdg_pkg::*;
#(
  parameter int unsigned MAX_SIDE  = 16,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // configuration
  input  logic                       cfg_we_i,
  input  logic [CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [CFG_W-1:0]           cfg_data_i,
  // command beats
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [OP_W-1:0]            op_i,
  input  logic [$clog2(MAX_SIDE**3)-1:0] voxel_addr_i,
  input  logic signed [DATA_W-1:0]   noise_value_i,
  // result beats
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [DATA_W-1:0]   conc_a_o,
  output logic signed [DATA_W-1:0]   conc_b_o
);

  localparam int unsigned DEPTH = MAX_SIDE ** 3;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned NW    = AW + 1;
  localparam int unsigned CW    = $clog2(MAX_SIDE);
  localparam int unsigned SW    = $clog2(MAX_SIDE + 1);
  localparam logic signed [DATA_W-1:0] FOUR = DATA_W'(4 << FRAC_BITS);

  // sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_RDW   = 3'd1;  // read data arriving
  localparam logic [2:0] ST_INIT  = 3'd2;  // set fields to 4.0
  localparam logic [2:0] ST_SRD   = 3'd3;  // issue center and neighbour reads
  localparam logic [2:0] ST_SWT   = 3'd4;  // last neighbour arriving
  localparam logic [2:0] ST_SCALC = 3'd5;  // delta pipeline busy
  localparam logic [2:0] ST_URD   = 3'd6;  // update read
  localparam logic [2:0] ST_UWR   = 3'd7;  // update write back

  // neighbour read order
  localparam logic [2:0] NB_CTR = 3'd0;
  localparam logic [2:0] NB_XM  = 3'd1;
  localparam logic [2:0] NB_XP  = 3'd2;
  localparam logic [2:0] NB_YM  = 3'd3;
  localparam logic [2:0] NB_YP  = 3'd4;
  localparam logic [2:0] NB_ZM  = 3'd5;
  localparam logic [2:0] NB_ZP  = 3'd6;

  // ---- configuration registers ----
  logic [SIDE_W-1:0] side_x_q, side_y_q, side_z_q;
  logic [CNT_W-1:0]  iter_q;
  coeff_t            coeff_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_x_q       <= SIDE_W'(16);
      side_y_q       <= SIDE_W'(16);
      side_z_q       <= SIDE_W'(16);
      iter_q         <= CNT_W'(100);
      coeff_q.spot   <= SPOT_W'(2368);
      coeff_q.diff_a <= DIFF_W'(8192);
      coeff_q.diff_b <= DIFF_W'(2048);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SIDE_X: side_x_q       <= cfg_data_i[SIDE_W-1:0];
        CFG_SIDE_Y: side_y_q       <= cfg_data_i[SIDE_W-1:0];
        CFG_SIDE_Z: side_z_q       <= cfg_data_i[SIDE_W-1:0];
        CFG_ITER:   iter_q         <= cfg_data_i[CNT_W-1:0];
        CFG_SPOT:   coeff_q.spot   <= cfg_data_i[SPOT_W-1:0];
        CFG_DIFF_A: coeff_q.diff_a <= cfg_data_i;
        CFG_DIFF_B: coeff_q.diff_b <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // effective extents: zero acts as one, oversize clamps to the grid
  function automatic logic [SW-1:0] eff_side(input logic [SIDE_W-1:0] s);
    if (s == '0) return SW'(1);
    if (32'(s) > MAX_SIDE) return SW'(MAX_SIDE);
    return SW'(s);
  endfunction

  logic [SW-1:0] sx, sy, sz;
  logic [NW-1:0] plane, n_vox;

  always_comb begin
    sx    = eff_side(side_x_q);
    sy    = eff_side(side_y_q);
    sz    = eff_side(side_z_q);
    plane = NW'(sx) * NW'(sy);
    n_vox = plane * NW'(sz);
  end

  // ---- sequencer state ----
  logic [2:0]       state_q, state_d;
  logic [AW-1:0]    v_q;
  logic [CW-1:0]    i_q, j_q, k_q;
  logic [2:0]       nb_q;
  logic [CNT_W-1:0] it_q;
  logic             rd_ok_q;
  logic             out_valid_q;
  logic             go_q;
  logic             arr_vld_q;
  logic [2:0]       arr_idx_q;

  logic in_acc, addr_ok, last_vox, adv;
  calc_res_t calc_res;

  assign in_ready_o = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign in_acc     = in_valid_i && in_ready_o;
  assign addr_ok    = {1'b0, voxel_addr_i} < n_vox;
  assign last_vox   = (i_q == CW'(sx - SW'(1))) && (j_q == CW'(sy - SW'(1)))
                   && (k_q == CW'(sz - SW'(1)));
  // step to the next voxel in raster order
  assign adv = (state_q == ST_INIT) || (state_q == ST_UWR)
            || ((state_q == ST_SCALC) && calc_res.done);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (op_i)
            OP_RUN:  state_d = ST_INIT;
            OP_READ: state_d = ST_RDW;
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_RDW:  state_d = ST_IDLE;
      ST_INIT: begin
        if (last_vox) state_d = (iter_q == '0) ? ST_IDLE : ST_SRD;
      end
      ST_SRD:  if (nb_q == NB_ZP) state_d = ST_SWT;
      ST_SWT:  state_d = ST_SCALC;
      ST_SCALC: begin
        if (calc_res.done) state_d = last_vox ? ST_URD : ST_SRD;
      end
      ST_URD:  state_d = ST_UWR;
      ST_UWR: begin
        if (!last_vox) state_d = ST_URD;
        else if (it_q + CNT_W'(1) == iter_q) state_d = ST_IDLE;
        else state_d = ST_SRD;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      v_q         <= '0;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      nb_q        <= NB_CTR;
      it_q        <= '0;
      rd_ok_q     <= 1'b0;
      out_valid_q <= 1'b0;
      go_q        <= 1'b0;
      arr_vld_q   <= 1'b0;
      arr_idx_q   <= NB_CTR;
    end else begin
      state_q   <= state_d;
      go_q      <= (state_q == ST_SWT);
      arr_vld_q <= (state_q == ST_SRD);
      arr_idx_q <= nb_q;

      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      if (state_q == ST_RDW) out_valid_q <= 1'b0 | 1'b1;

      if (in_acc && (op_i == OP_READ)) rd_ok_q <= addr_ok;
      if (in_acc && (op_i == OP_RUN)) begin
        v_q  <= '0;
        i_q  <= '0;
        j_q  <= '0;
        k_q  <= '0;
        it_q <= '0;
        nb_q <= NB_CTR;
      end

      if (state_q == ST_SRD) nb_q <= (nb_q == NB_ZP) ? NB_CTR : nb_q + 3'd1;
      if ((state_q == ST_UWR) && last_vox) it_q <= it_q + CNT_W'(1);

      if (adv) begin
        if (last_vox) begin
          v_q <= '0;
          i_q <= '0;
          j_q <= '0;
          k_q <= '0;
        end else begin
          v_q <= v_q + AW'(1);
          if (i_q == CW'(sx - SW'(1))) begin
            i_q <= '0;
            if (j_q == CW'(sy - SW'(1))) begin
              j_q <= '0;
              k_q <= k_q + CW'(1);
            end else begin
              j_q <= j_q + CW'(1);
            end
          end else begin
            i_q <= i_q + CW'(1);
          end
        end
      end
    end
  end

  // ---- neighbour address with periodic wrap ----
  logic [NW-1:0] vv, sxw, nb_addr_w;
  logic [AW-1:0] nb_addr;

  always_comb begin
    vv  = NW'(v_q);
    sxw = NW'(sx);
    case (nb_q)
      NB_XM:   nb_addr_w = (i_q == '0) ? vv + sxw - NW'(1) : vv - NW'(1);
      NB_XP:   nb_addr_w = (i_q == CW'(sx - SW'(1))) ? vv - (sxw - NW'(1)) : vv + NW'(1);
      NB_YM:   nb_addr_w = (j_q == '0) ? vv + plane - sxw : vv - sxw;
      NB_YP:   nb_addr_w = (j_q == CW'(sy - SW'(1))) ? vv - (plane - sxw) : vv + sxw;
      NB_ZM:   nb_addr_w = (k_q == '0) ? vv + n_vox - plane : vv - plane;
      NB_ZP:   nb_addr_w = (k_q == CW'(sz - SW'(1))) ? vv - (n_vox - plane) : vv + plane;
      default: nb_addr_w = vv;
    endcase
    nb_addr = nb_addr_w[AW-1:0];
  end

  // ---- memories: conc word {a, b}, aux word {noise, delta_a, delta_b} ----
  logic [2*DATA_W-1:0] conc_mem [DEPTH];
  logic [3*DATA_W-1:0] aux_mem  [DEPTH];
  logic [2*DATA_W-1:0] conc_rd_q, conc_wd;
  logic [3*DATA_W-1:0] aux_rd_q, aux_wd;
  logic [AW-1:0]       conc_ra, aux_wa;
  logic                conc_we, aux_we;
  logic signed [DATA_W-1:0] rd_a, rd_b, rd_da, rd_db;

  assign rd_a  = conc_rd_q[2*DATA_W-1:DATA_W];
  assign rd_b  = conc_rd_q[DATA_W-1:0];
  assign rd_da = aux_rd_q[2*DATA_W-1:DATA_W];
  assign rd_db = aux_rd_q[DATA_W-1:0];

  logic signed [DATA_W-1:0] noise_q;

  always_comb begin
    conc_ra = (state_q == ST_IDLE) ? voxel_addr_i : ((state_q == ST_SRD) ? nb_addr : v_q);
    conc_we = (state_q == ST_INIT) || (state_q == ST_UWR);
    conc_wd = (state_q == ST_INIT) ? {FOUR, FOUR}
            : {sat32(WIDE_W'(rd_a) + WIDE_W'(rd_da)), sat32(WIDE_W'(rd_b) + WIDE_W'(rd_db))};
    aux_we  = (in_acc && (op_i == OP_WRITE) && addr_ok)
           || ((state_q == ST_SCALC) && calc_res.done);
    aux_wa  = (state_q == ST_IDLE) ? voxel_addr_i : v_q;
    aux_wd  = (state_q == ST_IDLE) ? {noise_value_i, {(2*DATA_W){1'b0}}}
            : {noise_q, calc_res.delta_a, calc_res.delta_b};
  end

  always_ff @(posedge clk_i) begin
    if (conc_we) conc_mem[v_q] <= conc_wd;
    if (aux_we) aux_mem[aux_wa] <= aux_wd;
    conc_rd_q <= conc_mem[conc_ra];
    aux_rd_q  <= aux_mem[v_q];
  end

  // ---- stencil gather: center first, then six neighbours ----
  logic signed [DATA_W-1:0] ca_q, cb_q;
  logic signed [SUM_W-1:0]  suma_q, sumb_q;

  always_ff @(posedge clk_i) begin
    if (arr_vld_q) begin
      if (arr_idx_q == NB_CTR) begin
        ca_q    <= rd_a;
        cb_q    <= rd_b;
        noise_q <= aux_rd_q[3*DATA_W-1:2*DATA_W];
        suma_q  <= '0;
        sumb_q  <= '0;
      end else begin
        suma_q <= suma_q + SUM_W'(rd_a);
        sumb_q <= sumb_q + SUM_W'(rd_b);
      end
    end
  end

  rdg_delta_calc #(
    .FRAC_BITS (FRAC_BITS)
  ) u_calc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (go_q),
    .coeff_i (coeff_q),
    .a_i     (ca_q),
    .b_i     (cb_q),
    .noise_i (noise_q),
    .sum_a_i (suma_q),
    .sum_b_i (sumb_q),
    .res_o   (calc_res)
  );

  // ---- result beat; out-of-grid reads answer zero ----
  logic signed [DATA_W-1:0] conc_a_q, conc_b_q;

  always_ff @(posedge clk_i) begin
    if (state_q == ST_RDW) begin
      conc_a_q <= rd_ok_q ? rd_a : '0;
      conc_b_q <= rd_ok_q ? rd_b : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign conc_a_o    = conc_a_q;
  assign conc_b_o    = conc_b_q;

  // ---- checks ----
  a_calc_in_scalc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    calc_res.done |-> (state_q == ST_SCALC))
    else $error("delta pipeline finished outside its wait state");

  a_result_from_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ($past(state_q) == ST_RDW))
    else $error("result beat raised without a voxel read");

  a_conc_write_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    conc_we |-> !in_ready_o)
    else $error("concentration write while taking commands");

  a_gather_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go_q |-> (!arr_vld_q && (state_q == ST_SCALC)))
    else $error("delta pipeline started before gather finished");

endmodule

[tb/reaction_diffusion_grid_3d_test.sv]
// ---------------------------------------------------------------------------
// reaction_diffusion_grid_3d_test: self-checking bench of the 3d grid block
// noise writes, runs and voxel reads are predicted by a fixed-point grid
// model and every read beat is compared with the predicted concentrations
// ---------------------------------------------------------------------------
module reaction_diffusion_grid_3d_test
  import rdg_pkg::*;
;

  localparam int unsigned DEPTH     = 4096;
  localparam int unsigned ADDR_W    = 12;
  localparam int unsigned IDLE_MAX  = 5_000_000;  // above the longest run of the bench
  localparam int unsigned SETTLE    = 20;
  localparam int unsigned HOLD_LONG = 400;

  // one command beat plus the concentrations it should return
  typedef struct {
    bit                       pause;
    bit                       hold;
    logic [OP_W-1:0]          op;
    logic [ADDR_W-1:0]        addr;
    logic signed [DATA_W-1:0] noise;
    bit                       has_res;
    logic signed [DATA_W-1:0] exp_a;
    logic signed [DATA_W-1:0] exp_b;
  } cmd_t;

  typedef struct {
    logic signed [DATA_W-1:0] a;
    logic signed [DATA_W-1:0] b;
  } conc_pair_t;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     cfg_we_i;
  logic [CFG_IDX_W-1:0]     cfg_idx_i;
  logic [CFG_W-1:0]         cfg_data_i;
  logic                     in_valid_i;
  logic                     in_ready_o;
  logic [OP_W-1:0]          op_i;
  logic [ADDR_W-1:0]        voxel_addr_i;
  logic signed [DATA_W-1:0] noise_value_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  logic signed [DATA_W-1:0] conc_a_o;
  logic signed [DATA_W-1:0] conc_b_o;

  reaction_diffusion_grid_3d uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .op_i, .voxel_addr_i, .noise_value_i,
    .out_valid_o, .out_ready_i, .conc_a_o, .conc_b_o
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // ------------------------------------------------------------------------
  // grid model: registers and stores of the block, kept by the bench
  // ------------------------------------------------------------------------
  logic [SIDE_W-1:0]  m_side_x, m_side_y, m_side_z;
  logic [CNT_W-1:0]   m_iters;
  logic [SPOT_W-1:0]  m_spot;
  logic [DIFF_W-1:0]  m_diff_a, m_diff_b;

  longint grid_a[DEPTH];
  longint grid_b[DEPTH];
  longint noise_mem[DEPTH];
  longint delta_a[DEPTH];
  longint delta_b[DEPTH];

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic int eff_side(input logic [SIDE_W-1:0] s);
    if (s == 0) return 1;
    if (s > 16) return 16;
    return int'(s);
  endfunction

  function automatic longint eff_diff(input logic [DIFF_W-1:0] d);
    return (d > DIFF_ONE) ? longint'(DIFF_ONE) : longint'(d);
  endfunction

  function automatic int active_voxels();
    return eff_side(m_side_x) * eff_side(m_side_y) * eff_side(m_side_z);
  endfunction

  // six-neighbour laplacian with wraparound, on field a or field b
  function automatic longint laplacian(input bit on_b, input int i, input int j,
                                       input int k, input int sx, input int sy,
                                       input int sz);
    int     pl;
    int     nb[6];
    longint s;
    pl = sx * sy;
    nb[0] = (i + sx - 1) % sx + j * sx + k * pl;
    nb[1] = (i + 1) % sx + j * sx + k * pl;
    nb[2] = i + ((j + sy - 1) % sy) * sx + k * pl;
    nb[3] = i + ((j + 1) % sy) * sx + k * pl;
    nb[4] = i + j * sx + ((k + sz - 1) % sz) * pl;
    nb[5] = i + j * sx + ((k + 1) % sz) * pl;
    s = 0;
    for (int q = 0; q < 6; q++) s += on_b ? grid_b[nb[q]] : grid_a[nb[q]];
    s -= 6 * (on_b ? grid_b[i + j * sx + k * pl] : grid_a[i + j * sx + k * pl]);
    return s;
  endfunction

  // whole simulation run: set both fields to 4.0, then jacobi sweeps
  task automatic simulate_run();
    int     sx, sy, sz, n;
    longint f, da, db, ab, ra, rb;
    sx = eff_side(m_side_x);
    sy = eff_side(m_side_y);
    sz = eff_side(m_side_z);
    n  = sx * sy * sz;
    f  = longint'(m_spot);
    da = eff_diff(m_diff_a);
    db = eff_diff(m_diff_b);
    for (int v = 0; v < n; v++) begin
      grid_a[v] = 64'sd4 <<< 16;
      grid_b[v] = 64'sd4 <<< 16;
    end
    for (int it = 0; it < int'(m_iters); it++) begin
      for (int v = 0; v < n; v++) begin
        // >>> on a signed longint floors, as the block does
        ab = clamp32((grid_a[v] * grid_b[v]) >>> 16);
        ra = clamp32((64'sd16 <<< 16) - ab);
        rb = clamp32(ab - grid_b[v] - noise_mem[v]);
        delta_a[v] = clamp32(((f * ra) >>> 16) + ((da * laplacian(1'b0, v % sx,
                     (v / sx) % sy, (v / sx) / sy, sx, sy, sz)) >>> 16));
        delta_b[v] = clamp32(((f * rb) >>> 16) + ((db * laplacian(1'b1, v % sx,
                     (v / sx) % sy, (v / sx) / sy, sx, sy, sz)) >>> 16));
      end
      for (int v = 0; v < n; v++) begin
        grid_a[v] = clamp32(grid_a[v] + delta_a[v]);
        grid_b[v] = clamp32(grid_b[v] + delta_b[v]);
      end
    end
  endtask

  // ------------------------------------------------------------------------
  // stimulus queue, driver, receiver and checker
  // ------------------------------------------------------------------------
  cmd_t       pending_cmds[$];
  conc_pair_t conc_expect[$];
  cmd_t       cur_cmd;
  bit         took;
  int         gap_left;
  int         burst_left;
  int         errors;
  int         hold_reqs;
  int         hold_done;
  int         hold_left;
  int         stall_phase;
  bit         stall_mode;
  int         idle_cycles;

  // queue one command and work out its effect on the model
  task automatic push_cmd(input logic [OP_W-1:0] op, input int addr,
                          input logic signed [DATA_W-1:0] noise);
    cmd_t c;
    bit   ok;
    c = '{pause: 1'b0, hold: 1'b0, op: op, addr: addr[ADDR_W-1:0], noise: noise,
          has_res: 1'b0, exp_a: '0, exp_b: '0};
    ok = addr < active_voxels();
    case (op)
      OP_WRITE: begin
        if (ok) noise_mem[addr] = longint'(noise);
      end
      OP_RUN: simulate_run();
      OP_READ: begin
        c.has_res = 1'b1;
        c.exp_a   = ok ? grid_a[addr][DATA_W-1:0] : '0;
        c.exp_b   = ok ? grid_b[addr][DATA_W-1:0] : '0;
      end
      default: ;  // unused op code, nothing happens
    endcase
    pending_cmds.insert(pending_cmds.size(), c);
  endtask

  task automatic push_pause();
    cmd_t c;
    c = '{pause: 1'b1, hold: 1'b0, op: OP_WRITE, addr: '0, noise: '0, has_res: 1'b0,
          exp_a: '0, exp_b: '0};
    pending_cmds.insert(pending_cmds.size(), c);
  endtask

  task automatic wait_idle();
    while (pending_cmds.size() != 0 || in_valid_i || conc_expect.size() != 0)
      @(negedge clk_i);
    // the block may still be finishing a run that has no result beat
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val[CFG_W-1:0];
    case (idx)
      CFG_SIDE_X: m_side_x = val[SIDE_W-1:0];
      CFG_SIDE_Y: m_side_y = val[SIDE_W-1:0];
      CFG_SIDE_Z: m_side_z = val[SIDE_W-1:0];
      CFG_ITER:   m_iters  = val[CNT_W-1:0];
      CFG_SPOT:   m_spot   = val[SPOT_W-1:0];
      CFG_DIFF_A: m_diff_a = val[DIFF_W-1:0];
      CFG_DIFF_B: m_diff_b = val[DIFF_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic signed [DATA_W-1:0] rand_noise();
    case ($urandom_range(0, 7))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $signed(32'($urandom_range(0, 32'h3ffff)) - 32'sh20000);
      default: return $signed($urandom());
    endcase
  endfunction

  // one setting: program the registers, fill the noise, run, then mixed traffic
  task automatic run_phase(input int sx, input int sy, input int sz, input int iters,
                           input int spot, input int da, input int db,
                           input int n_mixed, input bit long_hold, input bit mid_pause);
    int n, r, a;
    wait_idle();
    cfg_write(CFG_SIDE_X, sx);
    cfg_write(CFG_SIDE_Y, sy);
    cfg_write(CFG_SIDE_Z, sz);
    cfg_write(CFG_ITER, iters);
    cfg_write(CFG_SPOT, spot);
    cfg_write(CFG_DIFF_A, da);
    cfg_write(CFG_DIFF_B, db);
    n = active_voxels();
    for (int v = 0; v < n; v++) push_cmd(OP_WRITE, v, rand_noise());
    push_cmd(OP_RUN, $urandom_range(0, DEPTH - 1), rand_noise());
    for (int q = 0; q < n_mixed; q++) begin
      if (mid_pause && q == n_mixed / 2) push_pause();
      r = $urandom_range(0, 99);
      a = $urandom_range(0, n - 1);
      if (r < 70) push_cmd(OP_READ, a, rand_noise());
      else if (r < 80 && n < DEPTH)
        push_cmd(OP_READ, $urandom_range(n, DEPTH - 1), rand_noise());
      else if (r < 88) push_cmd(OP_WRITE, a, rand_noise());
      else if (r < 93 && n < DEPTH)
        push_cmd(OP_WRITE, $urandom_range(n, DEPTH - 1), rand_noise());
      else if (r < 96) push_cmd(OP_RUN, a, rand_noise());
      else push_cmd(OP_UNUSED, $urandom_range(0, DEPTH - 1), rand_noise());
      // receiver holds off once the first mixed beat goes in, reads then pile up
      if (long_hold && q == 0) pending_cmds[pending_cmds.size() - 1].hold = 1'b1;
    end
    // a closing read cannot finish before a preceding run does
    push_cmd(OP_READ, $urandom_range(0, n - 1), rand_noise());
  endtask

  // driver: next beat at the falling edge, bursts with random gaps
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || took)) begin
      took <= 1'b0;
      if (pending_cmds.size() != 0 && pending_cmds[0].pause) begin
        in_valid_i <= 1'b0;
        if (conc_expect.size() == 0) void'(pending_cmds.pop_front());
      end else if (gap_left > 0) begin
        in_valid_i <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_cmds.size() != 0) begin
        cur_cmd        = pending_cmds.pop_front();
        in_valid_i    <= 1'b1;
        op_i          <= cur_cmd.op;
        voxel_addr_i  <= cur_cmd.addr;
        noise_value_i <= cur_cmd.noise;
        if (burst_left > 0) begin
          burst_left <= burst_left - 1;
        end else begin
          burst_left <= $urandom_range(0, 30);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // beat taken: its expectation becomes due
  always @(posedge clk_i) begin
    conc_pair_t p;
    if (rst_ni && in_valid_i && in_ready_o) begin
      took <= 1'b1;
      if (cur_cmd.hold) hold_reqs <= hold_reqs + 1;
      if (cur_cmd.has_res) begin
        p = '{a: cur_cmd.exp_a, b: cur_cmd.exp_b};
        conc_expect.insert(conc_expect.size(), p);
      end
    end
  end

  // receiver: own stall pattern, plus long hold-offs on request
  always @(negedge clk_i) begin
    if (rst_ni) begin
      stall_phase <= stall_phase + 1;
      if (stall_phase % 97 == 0) stall_mode <= $urandom_range(0, 1);
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left   <= hold_left - 1;
      end else if (hold_done != hold_reqs) begin
        out_ready_i <= 1'b0;
        hold_left   <= HOLD_LONG;
        hold_done   <= hold_done + 1;
      end else begin
        out_ready_i <= stall_mode ? ($urandom_range(0, 2) != 0) : 1'b1;
      end
    end
  end

  // checker: every read beat against the oldest expectation
  always @(posedge clk_i) begin
    conc_pair_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (conc_expect.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected read beat: a=%h b=%h", conc_a_o, conc_b_o);
      end else begin
        e = conc_expect.pop_front();
        if (conc_a_o !== e.a || conc_b_o !== e.b) begin
          errors++;
          if (errors <= 10)
            $display("read beat mismatch: a=%h (exp %h) b=%h (exp %h)",
                     conc_a_o, e.a, conc_b_o, e.b);
        end
      end
    end
  end

  // watchdog on cycles with no beat on either channel
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_MAX) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ------------------------------------------------------------------------
  // sequence of the run
  // ------------------------------------------------------------------------
  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0; cfg_idx_i = '0; cfg_data_i = '0;
    in_valid_i = 1'b0; op_i = '0; voxel_addr_i = '0; noise_value_i = '0;
    out_ready_i = 1'b0;
    took = 1'b0; gap_left = 0; burst_left = 0; errors = 0;
    hold_reqs = 0; hold_done = 0; hold_left = 0; stall_phase = 0; stall_mode = 1'b0;
    idle_cycles = 0;
    m_side_x = 16; m_side_y = 16; m_side_z = 16;
    m_iters = 100; m_spot = 2368; m_diff_a = 17'd8192; m_diff_b = 17'd2048;
    for (int v = 0; v < DEPTH; v++) begin
      grid_a[v] = 0; grid_b[v] = 0; noise_mem[v] = 0;
      delta_a[v] = 0; delta_b[v] = 0;
    end
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: full grid after reset, extreme addresses and noise, unused op
    push_cmd(OP_WRITE, 0, 32'sh7fffffff);
    push_cmd(OP_WRITE, DEPTH - 1, 32'sh80000000);
    push_cmd(OP_UNUSED, DEPTH - 1, 32'sh7fffffff);
    push_cmd(OP_UNUSED, 0, 32'sh0);

    // directed settings: extreme sides, zero and one sweep, saturating coefficients
    run_phase(16, 1, 1, 0, 1, 0, 0, 4, 1'b0, 1'b0);            // zero sweeps
    run_phase(1, 16, 1, 1, 65535, 65536, 65536, 4, 1'b0, 1'b0);
    run_phase(0, 0, 17, 2, 65535, 131071, 131071, 4, 1'b0, 1'b0); // clamped sides
    run_phase(31, 2, 0, 1, 40000, 70000, 0, 4, 1'b0, 1'b0);
    run_phase(0, 0, 0, 65535, 2368, 8192, 2048, 2, 1'b0, 1'b0);   // longest sweep count
    run_phase(2, 2, 2, 3, 0, 0, 131071, 3, 1'b0, 1'b0);

    // random settings, small grids and few sweeps keep runs short
    for (int p = 0; p < 15; p++)
      run_phase($urandom_range(0, 4), $urandom_range(1, 4), $urandom_range(1, 4),
                $urandom_range(0, 6), $urandom_range(0, 65535),
                $urandom_range(0, 131071), $urandom_range(0, 131071),
                $urandom_range(40, 80), p == 3 || p == 9, p == 5);

    wait_idle();
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
